>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled during rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// invariant
`define ASSERT_INV(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

>>> src/atpe_pkg.sv
// ---------------------------------------------------------------------------
// atpe_pkg
// Types and constants shared by the axis threshold press event blocks.
// ---------------------------------------------------------------------------
package atpe_pkg;

  localparam logic [6:0] PCT_MAX   = 7'd100;
  localparam logic [6:0] PCT_RESET = 7'd50;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CLS_NEU = 2'd0,
    CLS_NEG = 2'd1,
    CLS_POS = 2'd2
  } axis_class_t;

  // one sample request with its threshold terms
  typedef struct packed {
    logic [1:0]         slot;
    logic [2:0]         axis;
    logic signed [16:0] diff_last;
    logic signed [16:0] diff_now;
    logic [22:0]        up_prod;
    logic [22:0]        dn_prod;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

>>> src/atpe_fifo.sv
// ---------------------------------------------------------------------------
// atpe_fifo
// Short queue of sample requests with their threshold terms between front and back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module atpe_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  atpe_pkg::entry_t  push_data,
  input  logic              pop,
  output atpe_pkg::qstat_t  stat,
  output atpe_pkg::entry_t  head
);
  import atpe_pkg::*;

  entry_t              buf_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head       = buf_q[rd_ptr];
  assign stat.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  `ASSERT_IMP(a_push_room, push, !stat.full, "push into full queue")
  `ASSERT_IMP(a_pop_data, pop, !stat.empty, "pop from empty queue")
  `ASSERT_INV(a_count_max, count <= (QPTR_W + 1)'(QUEUE_DEPTH), "queue count overflow")

endmodule

>>> src/atpe_front.sv
// ---------------------------------------------------------------------------
// atpe_front
// Accept beats, hold per-axis center and last sample, form threshold terms.
// ---------------------------------------------------------------------------
module atpe_front #(
  parameter int NUM_SLOTS     = 4,
  parameter int AXES_PER_SLOT = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [1:0]        slot,
  input  logic [2:0]        axis,
  input  logic signed [15:0] sample,
  input  logic [6:0]        pct,
  input  atpe_pkg::qstat_t  qstat,
  output logic              push,
  output atpe_pkg::entry_t  push_data
);
  import atpe_pkg::*;

  localparam int AXIS_COUNT = NUM_SLOTS * AXES_PER_SLOT;
  localparam int IDX_W      = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  logic signed [15:0] center_mem [AXIS_COUNT];
  logic signed [15:0] last_mem   [AXIS_COUNT];
  logic [AXIS_COUNT-1:0] written;

  logic               s1_valid;
  logic               s1_req;
  logic [1:0]         s1_slot;
  logic [2:0]         s1_axis;
  logic signed [15:0] s1_sample;
  logic [IDX_W-1:0]   s1_idx;
  logic signed [15:0] center_q;
  logic signed [15:0] last_q;

  logic               in_range;
  logic               take;
  logic               s1_adv;
  logic [31:0]        idx_sum;
  logic [IDX_W-1:0]   rd_idx;
  logic signed [15:0] wr_center;
  logic [15:0]        e_span;
  logic [15:0]        d_span;

  assign in_range = (int'(slot) < NUM_SLOTS) && (int'(axis) < AXES_PER_SLOT);
  assign idx_sum  = 32'(int'(slot) * AXES_PER_SLOT + int'(axis));
  assign rd_idx   = idx_sum[IDX_W-1:0];
  assign s1_adv   = s1_valid && ((s1_req == REQ_LOAD) || !qstat.full);
  assign in_ready = !s1_valid || s1_adv;
  assign take     = in_valid && in_ready && in_range;

  assign wr_center = (s1_req == REQ_SAMPLE) ? center_q : s1_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      written  <= '0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        written[s1_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      center_mem[s1_idx] <= wr_center;
      last_mem[s1_idx]   <= s1_sample;
    end
  end

  // read with write-first bypass
  always_ff @(posedge clk) begin
    if (take) begin
      s1_req    <= req_type;
      s1_slot   <= slot;
      s1_axis   <= axis;
      s1_sample <= sample;
      s1_idx    <= rd_idx;
      if (s1_adv && (s1_idx == rd_idx)) begin
        center_q <= wr_center;
        last_q   <= s1_sample;
      end else if (written[rd_idx]) begin
        center_q <= center_mem[rd_idx];
        last_q   <= last_mem[rd_idx];
      end else begin
        center_q <= '0;
        last_q   <= '0;
      end
    end
  end

  // e_span = center + 32768, d_span = 32767 - center
  assign e_span = {~center_q[15], center_q[14:0]};
  assign d_span = ~e_span;

  assign push                = s1_adv && (s1_req == REQ_SAMPLE);
  assign push_data.slot      = s1_slot;
  assign push_data.axis      = s1_axis;
  assign push_data.diff_last = $signed({last_q[15], last_q}) - $signed({center_q[15], center_q});
  assign push_data.diff_now  = $signed({s1_sample[15], s1_sample})
                               - $signed({center_q[15], center_q});
  assign push_data.up_prod   = 23'(d_span) * 23'(pct);
  assign push_data.dn_prod   = 23'(e_span) * 23'(pct);

endmodule

>>> src/atpe_back.sv
// ---------------------------------------------------------------------------
// atpe_back
// Compare against thresholds and emit negative then positive events.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module atpe_back (
  input  logic              clk,
  input  logic              rst,
  input  atpe_pkg::qstat_t  qstat,
  input  atpe_pkg::entry_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_slot,
  output logic [2:0]        out_axis,
  output logic              positive_dir,
  output logic              pressed,
  output logic              last_of_run
);
  import atpe_pkg::*;

  // positive when 100*diff > up_prod, negative when 100*diff < -dn_prod
  function automatic axis_class_t classify(input logic signed [16:0] diff,
                                           input logic [22:0] up_prod,
                                           input logic [22:0] dn_prod);
    logic signed [24:0] scaled;
    scaled = 25'(diff) * 25'sd100;
    if (scaled > $signed({2'b00, up_prod})) begin
      return CLS_POS;
    end else if ((scaled + $signed({2'b00, dn_prod})) < 25'sd0) begin
      return CLS_NEG;
    end else begin
      return CLS_NEU;
    end
  endfunction

  axis_class_t prev_cls;
  axis_class_t cur_cls;
  logic        need_neg;
  logic        need_pos;
  logic        sent_neg;
  logic        sent_neg_next;
  logic        out_free;
  logic        emit;
  logic        emit_pos;
  logic        emit_pressed;
  logic        emit_last;

  assign prev_cls = classify(head.diff_last, head.up_prod, head.dn_prod);
  assign cur_cls  = classify(head.diff_now, head.up_prod, head.dn_prod);
  assign need_neg = (prev_cls != cur_cls) && ((prev_cls == CLS_NEG) || (cur_cls == CLS_NEG));
  assign need_pos = (prev_cls != cur_cls) && ((prev_cls == CLS_POS) || (cur_cls == CLS_POS));
  assign out_free = !out_valid || out_ready;

  always_comb begin
    pop           = 1'b0;
    emit          = 1'b0;
    emit_pos      = 1'b0;
    emit_pressed  = 1'b0;
    emit_last     = 1'b0;
    sent_neg_next = sent_neg;
    if (!qstat.empty) begin
      if (!need_neg && !need_pos) begin
        pop = 1'b1;
      end else if (out_free) begin
        emit = 1'b1;
        if (need_neg && !sent_neg) begin
          emit_pressed = (cur_cls == CLS_NEG);
          emit_last    = !need_pos;
          if (need_pos) begin
            sent_neg_next = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end else begin
          emit_pos      = 1'b1;
          emit_pressed  = (cur_cls == CLS_POS);
          emit_last     = 1'b1;
          sent_neg_next = 1'b0;
          pop           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sent_neg  <= 1'b0;
    end else begin
      sent_neg <= sent_neg_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_slot     <= head.slot;
      out_axis     <= head.axis;
      positive_dir <= emit_pos;
      pressed      <= emit_pressed;
      last_of_run  <= emit_last;
    end
  end

  `ASSERT_IMP(a_split_pending, sent_neg, !qstat.empty, "split run lost its entry")
  `ASSERT_IMP(a_split_beat, sent_neg, out_valid && !last_of_run && !positive_dir, "split state without negative beat")
  `ASSERT_NXT(a_run_follow, out_valid && out_ready && !last_of_run, out_valid && last_of_run && positive_dir, "run not completed by positive beat")

endmodule

>>> src/axis_threshold_press_events.sv
// A sample beat is registered in the front-end stage and pushed into the queue; its first
// event beat is then registered onto m_axis_tvalid, and a run's second event follows once
// the first is taken. Throughput: one beat per cycle into a 4-entry queue while it has room;
// the emitter drains one event per cycle while m_axis_tready is high. Reset (synchronous rst):
// clears all axis centers and last samples to zero through per-axis valid bits, empties the
// queue and sets the press threshold to 50 percent. No clearing pass.
// ---------------------------------------------------------------------------
// axis_threshold_press_events
// Stream of analog axis samples in, digital press and release events out.
// ---------------------------------------------------------------------------
module axis_threshold_press_events #(
  parameter int NUM_SLOTS     = 4,
  parameter int AXES_PER_SLOT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,     // press threshold, percent
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // slot[1:0], axis[4:2], sample[20:5], zero[23:21]
  input  logic [0:0]  s_axis_tuser,    // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // out_slot[1:0], out_axis[4:2], zero[7:5]
  output logic [1:0]  m_axis_tuser,    // positive_dir[0], pressed[1]
  output logic        m_axis_tlast     // last_of_run
);
  import atpe_pkg::*;

  logic [6:0] pct;
  qstat_t     qstat;
  logic       push;
  entry_t     push_data;
  logic       pop;
  entry_t     head;
  logic [1:0] out_slot;
  logic [2:0] out_axis;
  logic       positive_dir;
  logic       pressed;

  always_ff @(posedge clk) begin
    if (rst) begin
      pct <= PCT_RESET;
    end else if (cfg_wr_en) begin
      pct <= (cfg_wr_data > PCT_MAX) ? PCT_MAX : cfg_wr_data;
    end
  end

  atpe_front #(
    .NUM_SLOTS     (NUM_SLOTS),
    .AXES_PER_SLOT (AXES_PER_SLOT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .req_type  (s_axis_tuser[0]),
    .slot      (s_axis_tdata[1:0]),
    .axis      (s_axis_tdata[4:2]),
    .sample    ($signed(s_axis_tdata[20:5])),
    .pct       (pct),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  atpe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .stat      (qstat),
    .head      (head)
  );

  atpe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .head         (head),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_slot     (out_slot),
    .out_axis     (out_axis),
    .positive_dir (positive_dir),
    .pressed      (pressed),
    .last_of_run  (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_axis, out_slot};
  assign m_axis_tuser = {pressed, positive_dir};

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives axis sample and center-load beats into axis_threshold_press_events
// and checks every press and release event beat against an in-bench
// predictor of the per-axis centers, last samples and threshold setting.
// Covers the extremes of every field, a sweep of threshold settings including
// zero and values past one hundred, random idling on both sides and a long output
// stall that backs up the input.
// ---------------------------------------------------------------------------
module testbench;
  import atpe_pkg::*;

  typedef struct {
    logic [1:0] slot;
    logic [2:0] axis;
    logic       positive_dir;
    logic       pressed;
    logic       last_of_run;
  } press_evt_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic signed [15:0] axis_ctr [32];
  logic signed [15:0] axis_last_smp [32];
  logic [6:0]         threshold_pct = PCT_RESET;
  press_evt_t         press_events_q [$];
  int                 fail_count = 0;
  bit                 idle_en = 1'b1;
  int                 hold_off_req = 0;

  axis_threshold_press_events u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int eff_pct();
    return (threshold_pct > PCT_MAX) ? int'(PCT_MAX) : int'(threshold_pct);
  endfunction

  function automatic void threshold_bounds(input logic signed [15:0] ctr, input int p,
                                           output int upper, output int lower);
    int c;
    c = int'(ctr);
    upper = c + ((32767 - c) * p) / 100;
    lower = c - ((c + 32768) * p) / 100;
  endfunction

  function automatic axis_class_t classify_level(input logic signed [15:0] pos,
                                                 input logic signed [15:0] ctr);
    int upper, lower, v;
    threshold_bounds(ctr, eff_pct(), upper, lower);
    v = int'(pos);
    if (v > upper) return CLS_POS;
    if (v < lower) return CLS_NEG;
    return CLS_NEU;
  endfunction

  task automatic predict_events(input logic req, input logic [1:0] slot,
                                input logic [2:0] axis, input logic signed [15:0] smp);
    logic [4:0]  idx;
    axis_class_t prev, cur;
    press_evt_t  ev;
    int          n;
    idx = {slot, axis};
    if (req == REQ_LOAD) begin
      axis_ctr[idx] = smp;
      axis_last_smp[idx] = smp;
      return;
    end
    prev = classify_level(axis_last_smp[idx], axis_ctr[idx]);
    cur = classify_level(smp, axis_ctr[idx]);
    axis_last_smp[idx] = smp;
    if (prev == cur) return;
    n = 0;
    ev.slot = slot;
    ev.axis = axis;
    ev.last_of_run = 1'b0;
    if (prev == CLS_NEG || cur == CLS_NEG) begin
      ev.positive_dir = 1'b0;
      ev.pressed = (cur == CLS_NEG);
      press_events_q.push_back(ev);
      n++;
    end
    if (prev == CLS_POS || cur == CLS_POS) begin
      ev.positive_dir = 1'b1;
      ev.pressed = (cur == CLS_POS);
      press_events_q.push_back(ev);
      n++;
    end
    if (n > 0) press_events_q[press_events_q.size() - 1].last_of_run = 1'b1;
  endtask

  task automatic send_axis_beat(input logic req, input logic [1:0] slot,
                                input logic [2:0] axis, input logic signed [15:0] smp);
    int gap;
    gap = idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, smp, axis, slot};
    s_axis_tuser <= req;
    do @(posedge clk); while (!s_axis_tready);
    predict_events(req, slot, axis, smp);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (press_events_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [6:0] pct);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= pct;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    threshold_pct = pct;
  endtask

  function automatic logic signed [15:0] pick_center();
    int r;
    r = $urandom_range(0, 99);
    if (r < 7) return 16'sh8000;
    if (r < 14) return 16'sh7FFF;
    if (r < 20) return 16'sh0000;
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] pick_sample(input logic [4:0] idx);
    int r, upper, lower, v;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 3))
        0: return 16'sh8000;
        1: return 16'sh7FFF;
        2: return 16'sh0000;
        default: return axis_ctr[idx];
      endcase
    end
    if (r < 65) begin
      threshold_bounds(axis_ctr[idx], eff_pct(), upper, lower);
      v = ($urandom_range(0, 1) ? upper : lower) + int'($urandom_range(0, 4)) - 2;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
    end
    return 16'($urandom);
  endfunction

  task automatic run_random_mix(input int count);
    logic [4:0] focus, idx;
    focus = 5'($urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 10) focus = 5'($urandom);
      idx = ($urandom_range(0, 99) < 75) ? focus : 5'($urandom);
      if ($urandom_range(0, 99) < 8)
        send_axis_beat(REQ_LOAD, idx[4:3], idx[2:0], pick_center());
      else
        send_axis_beat(REQ_SAMPLE, idx[4:3], idx[2:0], pick_sample(idx));
      if ($urandom_range(0, 149) == 0) idle_en = !idle_en;
    end
    idle_en = 1'b1;
  endtask

  task automatic test_directed_extremes();
    // never-loaded axis: center and last sample start at zero
    send_axis_beat(REQ_SAMPLE, 2'd0, 3'd0, 16'sh7FFF);
    send_axis_beat(REQ_SAMPLE, 2'd0, 3'd0, 16'sh8000);
    send_axis_beat(REQ_SAMPLE, 2'd0, 3'd0, 16'sh8000);
    send_axis_beat(REQ_SAMPLE, 2'd0, 3'd0, 16'sh0000);
    // center at the top of the range: positive side unreachable
    send_axis_beat(REQ_LOAD, 2'd3, 3'd7, 16'sh7FFF);
    send_axis_beat(REQ_SAMPLE, 2'd3, 3'd7, 16'sh7FFF);
    send_axis_beat(REQ_SAMPLE, 2'd3, 3'd7, -16'sd1);
    send_axis_beat(REQ_SAMPLE, 2'd3, 3'd7, 16'sh0000);
    send_axis_beat(REQ_SAMPLE, 2'd3, 3'd7, 16'sh8000);
    // center at the bottom of the range: negative side unreachable
    send_axis_beat(REQ_LOAD, 2'd2, 3'd5, 16'sh8000);
    send_axis_beat(REQ_SAMPLE, 2'd2, 3'd5, -16'sd1);
    send_axis_beat(REQ_SAMPLE, 2'd2, 3'd5, 16'sh0000);
    send_axis_beat(REQ_SAMPLE, 2'd2, 3'd5, 16'sh8000);
    // off-center rest with full swings
    send_axis_beat(REQ_LOAD, 2'd1, 3'd2, 16'sh5555);
    send_axis_beat(REQ_SAMPLE, 2'd1, 3'd2, 16'sh7FFF);
    send_axis_beat(REQ_SAMPLE, 2'd1, 3'd2, 16'sh8000);
    send_axis_beat(REQ_SAMPLE, 2'd1, 3'd2, 16'sh2AAA);
    send_axis_beat(REQ_LOAD, 2'd1, 3'd2, 16'sh8000);
    send_axis_beat(REQ_SAMPLE, 2'd1, 3'd2, 16'sh7FFF);
    send_axis_beat(REQ_SAMPLE, 2'd3, 3'd7, 16'sh8000);
  endtask

  task automatic test_threshold_sweep();
    logic [6:0] pct_list [8];
    int         count_list [8];
    pct_list = '{7'd0, PCT_MAX, 7'd127, 7'd1, 7'd99, 7'($urandom_range(2, 98)),
                 7'($urandom_range(101, 126)), PCT_RESET};
    count_list = '{250, 100, 100, 250, 200, 250, 200, 200};
    run_random_mix(200);
    for (int k = 0; k < 8; k++) begin
      write_threshold(pct_list[k]);
      run_random_mix(count_list[k]);
    end
  endtask

  task automatic test_output_backpressure();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    hold_off_req = 300;
    @(posedge clk);
    idle_en = 1'b0;
    send_axis_beat(REQ_LOAD, 2'd0, 3'd1, 16'sh0000);
    for (int i = 0; i < 40; i++)
      send_axis_beat(REQ_SAMPLE, 2'd0, 3'd1, (i % 2) ? 16'sh8000 : 16'sh7FFF);
    idle_en = 1'b1;
  endtask

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      fail_count++;
    end
  endtask

  initial begin : event_sink
    int         stall_left, hold_left;
    press_evt_t ev;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (press_events_q.size() == 0) begin
          $error("unexpected event beat: slot %0d axis %0d", m_axis_tdata[1:0],
                 m_axis_tdata[4:2]);
          fail_count++;
        end else begin
          ev = press_events_q.pop_front();
          check_field("out_slot", int'(ev.slot), int'(m_axis_tdata[1:0]));
          check_field("out_axis", int'(ev.axis), int'(m_axis_tdata[4:2]));
          check_field("positive_dir", int'(ev.positive_dir), int'(m_axis_tuser[0]));
          check_field("pressed", int'(ev.pressed), int'(m_axis_tuser[1]));
          check_field("last_of_run", int'(ev.last_of_run), int'(m_axis_tlast));
        end
      end
      if (hold_off_req > 0) begin
        hold_left = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        stall_left = idle_en ? pick_gap() : 0;
        if (stall_left > 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) begin
      axis_ctr[i] = '0;
      axis_last_smp[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_threshold_sweep();
    test_output_backpressure();
    wait_idle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
